[hw/rtl/cir_pkg.sv]
// ============================================================================
// cir_pkg: shared types, constants and helpers of the contact impulse resolver
// Fixed-point formats, register codes, item structs and saturation.
// ============================================================================
package cir_pkg;

    localparam int VALUE_W    = 32;                   // Q16.16 value width
    localparam int FRAC_W     = 16;                   // fraction bits
    localparam int MASS_W     = 31;                   // unsigned inverse mass
    localparam int FRAC_CFG_W = 17;                   // fraction-style registers
    localparam int LIMIT_W    = 31;                   // slop and speed limit
    localparam int CFG_DATA_W = 31;                   // widest register
    localparam int TOTAL_W    = MASS_W + 1;           // summed inverse mass
    localparam int DIVIDEND_W = VALUE_W - 1 + FRAC_W; // non-negative value << 16
    localparam int DIV_STEPS  = DIVIDEND_W;           // one quotient bit per stage
    localparam int WIDE_W     = 72;                   // headroom for sums before clamp

    typedef logic signed [VALUE_W-1:0] val_t;
    typedef logic        [MASS_W-1:0]  mass_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    typedef enum logic [1:0] {
        CFG_CORR_FRAC  = 2'd0,
        CFG_PEN_SLOP   = 2'd1,
        CFG_BOUNCE     = 2'd2,
        CFG_SLOW_LIMIT = 2'd3
    } cfg_reg_t;

    localparam logic [FRAC_CFG_W-1:0] CORR_FRAC_RST  = FRAC_CFG_W'(9830);
    localparam logic [LIMIT_W-1:0]    PEN_SLOP_RST   = LIMIT_W'(655);
    localparam logic [FRAC_CFG_W-1:0] BOUNCE_RST     = FRAC_CFG_W'(13107);
    localparam logic [LIMIT_W-1:0]    SLOW_LIMIT_RST = LIMIT_W'(16384);

    localparam logic [FRAC_CFG_W:0] ONE_Q = (FRAC_CFG_W+1)'(1) << FRAC_W;
    localparam val_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct packed {
        mass_t inv_mass_a;
        mass_t inv_mass_b;
        val_t  normal_x;
        val_t  normal_y;
        val_t  normal_z;
        val_t  depth;
        val_t  vel_a_x;
        val_t  vel_a_y;
        val_t  vel_a_z;
        val_t  vel_b_x;
        val_t  vel_b_y;
        val_t  vel_b_z;
    } contact_t;

    typedef struct packed {
        val_t shift_a_x;
        val_t shift_a_y;
        val_t shift_a_z;
        val_t shift_b_x;
        val_t shift_b_y;
        val_t shift_b_z;
        val_t new_vel_a_x;
        val_t new_vel_a_y;
        val_t new_vel_a_z;
        val_t new_vel_b_x;
        val_t new_vel_b_y;
        val_t new_vel_b_z;
    } result_t;

    // Clamp to the signed value range.
    function automatic val_t sat_val(input wide_t x);
        wide_t hi;
        wide_t lo;
        val_t  r;
        hi = (wide_t'(1) <<< (VALUE_W - 1)) - wide_t'(1);
        lo = -hi - wide_t'(1);
        if (x > hi)
        begin
            r = hi[VALUE_W-1:0];
        end
        else if (x < lo)
        begin
            r = lo[VALUE_W-1:0];
        end
        else
        begin
            r = x[VALUE_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/cir_divider.sv]
// ============================================================================
// cir_divider: pipelined restoring divider
// Unsigned dividend by unsigned divisor, one quotient bit per register stage.
// ============================================================================
module cir_divider (
    input  logic                            clk,
    input  logic                            en,
    input  logic [cir_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [cir_pkg::TOTAL_W-1:0]     divisor,
    output logic [cir_pkg::DIVIDEND_W-1:0]  quotient
);

    localparam int DW    = cir_pkg::DIVIDEND_W;
    localparam int TW    = cir_pkg::TOTAL_W;
    localparam int STEPS = cir_pkg::DIV_STEPS;

    logic [TW-1:0] rem_reg   [STEPS];
    logic [DW-1:0] dq_reg    [STEPS];
    logic [TW-1:0] dv_reg    [STEPS];
    logic [TW-1:0] rem_in    [STEPS];
    logic [DW-1:0] dq_in     [STEPS];
    logic [TW-1:0] dv_in     [STEPS];
    logic [TW:0]   trial     [STEPS];
    logic [TW:0]   diff      [STEPS];
    logic          take      [STEPS];
    logic [TW-1:0] rem_next  [STEPS];
    logic [DW-1:0] dq_next   [STEPS];

    // dq holds the remaining dividend bits on top and collected quotient bits below
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            if (k == 0)
            begin
                rem_in[k] = '0;
                dq_in[k]  = dividend;
                dv_in[k]  = divisor;
            end
            else
            begin
                rem_in[k] = rem_reg[k-1];
                dq_in[k]  = dq_reg[k-1];
                dv_in[k]  = dv_reg[k-1];
            end
            trial[k]    = {rem_in[k], dq_in[k][DW-1]};
            diff[k]     = trial[k] - {1'b0, dv_in[k]};
            take[k]     = trial[k] >= {1'b0, dv_in[k]};
            rem_next[k] = take[k] ? diff[k][TW-1:0] : trial[k][TW-1:0];
            dq_next[k]  = {dq_in[k][DW-2:0], take[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                dq_reg[k]  <= dq_next[k];
                dv_reg[k]  <= dv_in[k];
            end
        end
    end

    assign quotient = dq_reg[STEPS-1];

endmodule

[hw/rtl/contact_impulse_resolver.sv]
// ============================================================================
// contact_impulse_resolver: impulse contact resolution with position correction
// Resolves one contact between two bodies per item, Q16.16 throughout.
// ============================================================================
// Usage:
//   contact channel (contact_valid/contact_ready/contact) takes one contact item
//   per cycle unless stalled; result channel (result_valid/result_ready/result)
//   returns one item per contact, in order. cfg_we/cfg_index/cfg_data write the
//   four tuning registers; write them only while no item is in flight.
// Pipeline: an accepted item passes 5 stages of products and sums, 47 stages
//   of the bit-per-stage dividers (correction share and impulse run side by
//   side), 5 stages of scaling and then the output register, which drives
//   result_valid.
// Throughput: one item per cycle while the receiver takes results.
// Stall: the output register has a one-item skid behind it; when both hold an
//   item the whole pipeline freezes and contact_ready drops until the skid
//   drains. Nothing is lost or repeated.
// Reset: clears all valid bits and loads the register defaults
//   (0.15, 0.01, 0.2, 0.25 in Q16.16).
// ============================================================================
module contact_impulse_resolver (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              contact_valid,
    output logic                              contact_ready,
    input  cir_pkg::contact_t                 contact,
    output logic                              result_valid,
    input  logic                              result_ready,
    output cir_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  cir_pkg::cfg_reg_t                 cfg_index,
    input  logic [cir_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int VW     = cir_pkg::VALUE_W;
    localparam int FW     = cir_pkg::FRAC_W;
    localparam int CW     = cir_pkg::FRAC_CFG_W;
    localparam int LW     = cir_pkg::LIMIT_W;
    localparam int TW     = cir_pkg::TOTAL_W;
    localparam int DW     = cir_pkg::DIVIDEND_W;
    localparam int STEPS  = cir_pkg::DIV_STEPS;
    localparam int STAGES = 5 + STEPS + 5;
    localparam int LAST   = STAGES - 1;

    typedef struct packed {
        cir_pkg::val_t [2:0] n;
        cir_pkg::val_t [2:0] va;
        cir_pkg::val_t [2:0] vb;
        cir_pkg::mass_t      ma;
        cir_pkg::mass_t      mb;
    } body_t;

    typedef struct packed {
        body_t body;
        logic  do_shift;
        logic  do_impulse;
    } carry_t;

    // ------------------------------------------------------------------ config
    logic [CW-1:0] corr_reg;
    logic [LW-1:0] slop_reg;
    logic [CW-1:0] bounce_reg;
    logic [LW-1:0] slow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corr_reg   <= cir_pkg::CORR_FRAC_RST;
            slop_reg   <= cir_pkg::PEN_SLOP_RST;
            bounce_reg <= cir_pkg::BOUNCE_RST;
            slow_reg   <= cir_pkg::SLOW_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cir_pkg::CFG_CORR_FRAC:  corr_reg   <= cfg_data[CW-1:0];
                cir_pkg::CFG_PEN_SLOP:   slop_reg   <= cfg_data[LW-1:0];
                cir_pkg::CFG_BOUNCE:     bounce_reg <= cfg_data[CW-1:0];
                cir_pkg::CFG_SLOW_LIMIT: slow_reg   <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ flow control
    logic              en;
    logic [STAGES-1:0] vld_reg;
    logic              out_vld_reg;
    logic              skid_vld_reg;

    assign en            = !skid_vld_reg;
    assign contact_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], contact_valid};
        end
    end

    // ------------------------------------------------- S1: totals, differences
    body_t               s1_body_next, s1_body_reg;
    logic [TW-1:0]       s1_total_next, s1_total_reg;
    logic signed [VW:0]  s1_e_next, s1_e_reg;
    logic signed [VW:0]  s1_d_next [3];
    logic signed [VW:0]  s1_d_reg  [3];

    always_comb
    begin
        s1_body_next.n[0]  = contact.normal_x;
        s1_body_next.n[1]  = contact.normal_y;
        s1_body_next.n[2]  = contact.normal_z;
        s1_body_next.va[0] = contact.vel_a_x;
        s1_body_next.va[1] = contact.vel_a_y;
        s1_body_next.va[2] = contact.vel_a_z;
        s1_body_next.vb[0] = contact.vel_b_x;
        s1_body_next.vb[1] = contact.vel_b_y;
        s1_body_next.vb[2] = contact.vel_b_z;
        s1_body_next.ma    = contact.inv_mass_a;
        s1_body_next.mb    = contact.inv_mass_b;
        s1_total_next = {1'b0, contact.inv_mass_a} + {1'b0, contact.inv_mass_b};
        s1_e_next = $signed({contact.depth[VW-1], contact.depth}) - $signed({2'b00, slop_reg});
        for (int i = 0; i < 3; i++)
        begin
            s1_d_next[i] = $signed({s1_body_next.vb[i][VW-1], s1_body_next.vb[i]})
                         - $signed({s1_body_next.va[i][VW-1], s1_body_next.va[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_body_reg  <= s1_body_next;
            s1_total_reg <= s1_total_next;
            s1_e_reg     <= s1_e_next;
            for (int i = 0; i < 3; i++)
            begin
                s1_d_reg[i] <= s1_d_next[i];
            end
        end
    end

    // --------------------------------------------------------- S2: products
    body_t                      s2_body_reg;
    logic [TW-1:0]              s2_total_reg;
    logic                       s2_epos_reg;
    logic signed [VW+CW+1:0]    s2_pe_reg;
    logic signed [2*VW:0]       s2_pr_reg [3];
    logic signed [2*VW-1:0]     s2_pa_reg [3];
    logic signed [2*VW-1:0]     s2_pb_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_body_reg  <= s1_body_reg;
            s2_total_reg <= s1_total_reg;
            s2_epos_reg  <= !s1_e_reg[VW] && (s1_e_reg != '0);
            s2_pe_reg    <= s1_e_reg * $signed({1'b0, corr_reg});
            for (int i = 0; i < 3; i++)
            begin
                s2_pr_reg[i] <= s1_d_reg[i] * $signed(s1_body_reg.n[i]);
                s2_pa_reg[i] <= $signed(s1_body_reg.va[i]) * $signed(s1_body_reg.n[i]);
                s2_pb_reg[i] <= $signed(s1_body_reg.vb[i]) * $signed(s1_body_reg.n[i]);
            end
        end
    end

    // ------------------------------------------------------ S3: dot products
    body_t          s3_body_reg;
    logic [TW-1:0]  s3_total_reg;
    logic           s3_epos_reg;
    cir_pkg::val_t  s3_s_reg, s3_r_reg, s3_da_reg, s3_db_reg;
    cir_pkg::wide_t sum_r, sum_a, sum_b;

    always_comb
    begin
        sum_r = '0;
        sum_a = '0;
        sum_b = '0;
        for (int i = 0; i < 3; i++)
        begin
            sum_r = sum_r + cir_pkg::wide_t'(s2_pr_reg[i] >>> FW);
            sum_a = sum_a + cir_pkg::wide_t'(s2_pa_reg[i] >>> FW);
            sum_b = sum_b + cir_pkg::wide_t'(s2_pb_reg[i] >>> FW);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_body_reg  <= s2_body_reg;
            s3_total_reg <= s2_total_reg;
            s3_epos_reg  <= s2_epos_reg;
            s3_s_reg     <= cir_pkg::sat_val(cir_pkg::wide_t'(s2_pe_reg >>> FW));
            s3_r_reg     <= cir_pkg::sat_val(sum_r);
            s3_da_reg    <= cir_pkg::sat_val(sum_a);
            s3_db_reg    <= cir_pkg::sat_val(sum_b);
        end
    end

    // ----------------------------------------- S4: case decision, bounce, strip
    body_t                   s4_body_reg;
    logic [TW-1:0]           s4_total_reg;
    logic                    s4_tot_nz_reg, s4_epos_reg, s4_sep_reg, s4_slow_reg;
    logic [DW-1:0]           s4_div_f_reg;
    logic signed [VW+CW+2:0] s4_pm_reg;
    logic signed [2*VW-1:0]  s4_qa_reg [3];
    logic signed [2*VW-1:0]  s4_qb_reg [3];
    logic signed [VW:0]      neg_r;
    logic [CW:0]             bounce_sum;

    assign neg_r      = -$signed({s3_r_reg[VW-1], s3_r_reg});
    assign bounce_sum = cir_pkg::ONE_Q + {1'b0, bounce_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_body_reg   <= s3_body_reg;
            s4_total_reg  <= s3_total_reg;
            s4_tot_nz_reg <= s3_total_reg != '0;
            s4_epos_reg   <= s3_epos_reg;
            s4_sep_reg    <= !s3_r_reg[VW-1] && (s3_r_reg != '0);
            s4_slow_reg   <= neg_r < $signed({2'b00, slow_reg});
            s4_div_f_reg  <= {s3_s_reg[VW-2:0], {FW{1'b0}}};
            s4_pm_reg     <= $signed({1'b0, bounce_sum}) * neg_r;
            for (int i = 0; i < 3; i++)
            begin
                s4_qa_reg[i] <= $signed(s3_body_reg.n[i]) * s3_da_reg;
                s4_qb_reg[i] <= $signed(s3_body_reg.n[i]) * s3_db_reg;
            end
        end
    end

    // ---------------------------------- S5: base velocities, divider operands
    carry_t         s5_car_next, s5_car_reg;
    logic [TW-1:0]  s5_total_reg;
    logic [DW-1:0]  s5_div_f_reg, s5_div_j_reg;
    cir_pkg::val_t  bounce_m;
    logic           use_strip;

    assign bounce_m  = cir_pkg::sat_val(cir_pkg::wide_t'(s4_pm_reg >>> FW));
    assign use_strip = s4_tot_nz_reg && !s4_sep_reg && s4_slow_reg;

    always_comb
    begin
        s5_car_next.body       = s4_body_reg;
        s5_car_next.do_shift   = s4_tot_nz_reg && s4_epos_reg;
        s5_car_next.do_impulse = s4_tot_nz_reg && !s4_sep_reg && !s4_slow_reg;
        if (use_strip)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_car_next.body.va[i] = cir_pkg::sat_val(
                    cir_pkg::wide_t'($signed(s4_body_reg.va[i]))
                    - cir_pkg::wide_t'(s4_qa_reg[i] >>> FW));
                s5_car_next.body.vb[i] = cir_pkg::sat_val(
                    cir_pkg::wide_t'($signed(s4_body_reg.vb[i]))
                    - cir_pkg::wide_t'(s4_qb_reg[i] >>> FW));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_car_reg   <= s5_car_next;
            s5_total_reg <= s4_total_reg;
            s5_div_f_reg <= s4_div_f_reg;
            s5_div_j_reg <= {bounce_m[VW-2:0], {FW{1'b0}}};
        end
    end

    // ------------------------------------------------------------- dividers
    logic [DW-1:0] quot_f, quot_j;
    carry_t        dcar_reg [STEPS];

    cir_divider u_div_corr (
        .clk      (clk),
        .en       (en),
        .dividend (s5_div_f_reg),
        .divisor  (s5_total_reg),
        .quotient (quot_f)
    );

    cir_divider u_div_impulse (
        .clk      (clk),
        .en       (en),
        .dividend (s5_div_j_reg),
        .divisor  (s5_total_reg),
        .quotient (quot_j)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dcar_reg[0] <= s5_car_reg;
            for (int k = 1; k < STEPS; k++)
            begin
                dcar_reg[k] <= dcar_reg[k-1];
            end
        end
    end

    // ------------------------------------------- P0..P4: scale along normal
    carry_t                 p0_car_reg, p1_car_reg, p2_car_reg, p3_car_reg;
    cir_pkg::val_t          p0_f_reg, p0_j_reg;
    logic signed [2*VW-1:0] p1_cf_reg [3];
    logic signed [2*VW-1:0] p1_ij_reg [3];
    cir_pkg::val_t          p2_c_reg  [3];
    cir_pkg::val_t          p2_i_reg  [3];
    logic signed [2*VW-1:0] p3_sa_reg [3];
    logic signed [2*VW-1:0] p3_sb_reg [3];
    logic signed [2*VW-1:0] p3_ia_reg [3];
    logic signed [2*VW-1:0] p3_ib_reg [3];
    cir_pkg::result_t       p4_res_next, p4_res_reg;
    logic                   p4_do_shift_reg;
    cir_pkg::val_t          sh_a [3];
    cir_pkg::val_t          sh_b [3];
    cir_pkg::val_t          nv_a [3];
    cir_pkg::val_t          nv_b [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_car_reg <= dcar_reg[STEPS-1];
            p0_f_reg   <= (|quot_f[DW-1:VW-1]) ? cir_pkg::VAL_MAX
                                               : {1'b0, quot_f[VW-2:0]};
            p0_j_reg   <= (|quot_j[DW-1:VW-1]) ? cir_pkg::VAL_MAX
                                               : {1'b0, quot_j[VW-2:0]};
            p1_car_reg <= p0_car_reg;
            p2_car_reg <= p1_car_reg;
            p3_car_reg <= p2_car_reg;
            for (int i = 0; i < 3; i++)
            begin
                p1_cf_reg[i] <= $signed(p0_car_reg.body.n[i]) * p0_f_reg;
                p1_ij_reg[i] <= $signed(p0_car_reg.body.n[i]) * p0_j_reg;
                p2_c_reg[i]  <= cir_pkg::sat_val(cir_pkg::wide_t'(p1_cf_reg[i] >>> FW));
                p2_i_reg[i]  <= cir_pkg::sat_val(cir_pkg::wide_t'(p1_ij_reg[i] >>> FW));
                p3_sa_reg[i] <= p2_c_reg[i] * $signed({1'b0, p2_car_reg.body.ma});
                p3_sb_reg[i] <= p2_c_reg[i] * $signed({1'b0, p2_car_reg.body.mb});
                p3_ia_reg[i] <= p2_i_reg[i] * $signed({1'b0, p2_car_reg.body.ma});
                p3_ib_reg[i] <= p2_i_reg[i] * $signed({1'b0, p2_car_reg.body.mb});
            end
            p4_res_reg      <= p4_res_next;
            p4_do_shift_reg <= p3_car_reg.do_shift;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh_a[i] = '0;
            sh_b[i] = '0;
            nv_a[i] = p3_car_reg.body.va[i];
            nv_b[i] = p3_car_reg.body.vb[i];
            if (p3_car_reg.do_shift)
            begin
                sh_a[i] = cir_pkg::sat_val(-cir_pkg::wide_t'(p3_sa_reg[i] >>> FW));
                sh_b[i] = cir_pkg::sat_val(cir_pkg::wide_t'(p3_sb_reg[i] >>> FW));
            end
            if (p3_car_reg.do_impulse)
            begin
                nv_a[i] = cir_pkg::sat_val(cir_pkg::wide_t'($signed(p3_car_reg.body.va[i]))
                                          - cir_pkg::wide_t'(p3_ia_reg[i] >>> FW));
                nv_b[i] = cir_pkg::sat_val(cir_pkg::wide_t'($signed(p3_car_reg.body.vb[i]))
                                          + cir_pkg::wide_t'(p3_ib_reg[i] >>> FW));
            end
        end
        p4_res_next.shift_a_x   = sh_a[0];
        p4_res_next.shift_a_y   = sh_a[1];
        p4_res_next.shift_a_z   = sh_a[2];
        p4_res_next.shift_b_x   = sh_b[0];
        p4_res_next.shift_b_y   = sh_b[1];
        p4_res_next.shift_b_z   = sh_b[2];
        p4_res_next.new_vel_a_x = nv_a[0];
        p4_res_next.new_vel_a_y = nv_a[1];
        p4_res_next.new_vel_a_z = nv_a[2];
        p4_res_next.new_vel_b_x = nv_b[0];
        p4_res_next.new_vel_b_y = nv_b[1];
        p4_res_next.new_vel_b_z = nv_b[2];
    end

    // ---------------------------------------------- output register and skid
    cir_pkg::result_t out_next, out_reg, skid_next, skid_reg;
    logic             out_vld_next, skid_vld_next;
    logic             push, pop;

    assign push = en && vld_reg[LAST];
    assign pop  = out_vld_reg && result_ready;

    always_comb
    begin
        out_next      = out_reg;
        skid_next     = skid_reg;
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (skid_vld_reg)
        begin
            if (pop)
            begin
                out_next      = skid_reg;
                skid_vld_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_vld_reg || pop)
            begin
                out_next     = p4_res_reg;
                out_vld_next = 1'b1;
            end
            else
            begin
                // hold the new item behind the stalled one
                skid_next     = p4_res_reg;
                skid_vld_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds an item while the output register is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !result_ready))
        else $error("skid filled without an output stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        contact_valid && contact_ready |=> vld_reg[0])
        else $error("accepted item missing from the first stage");

    a_no_shift_zero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAST] && !p4_do_shift_reg |->
            p4_res_reg.shift_a_x == '0 && p4_res_reg.shift_a_y == '0 &&
            p4_res_reg.shift_a_z == '0 && p4_res_reg.shift_b_x == '0 &&
            p4_res_reg.shift_b_y == '0 && p4_res_reg.shift_b_z == '0)
        else $error("position shift present without correction");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench: contact impulse resolver check
// Drives contact items with random gaps while result_ready stalls at random.
// A scoreboard predicts each result from its contact and the tuning registers
// and compares every field in order. Registers change only while idle.
// ============================================================================
module testbench;

    typedef logic signed [127:0] big_t;

    // Predicts resolved contacts and holds them until the block returns them.
    class contact_scoreboard;
        logic [cir_pkg::FRAC_CFG_W-1:0] corr_frac;
        logic [cir_pkg::LIMIT_W-1:0]    pen_slop;
        logic [cir_pkg::FRAC_CFG_W-1:0] bounce;
        logic [cir_pkg::LIMIT_W-1:0]    slow_limit;
        cir_pkg::result_t               pending[$];
        string                          faults[$];

        function void load_defaults();
            corr_frac  = cir_pkg::CORR_FRAC_RST;
            pen_slop   = cir_pkg::PEN_SLOP_RST;
            bounce     = cir_pkg::BOUNCE_RST;
            slow_limit = cir_pkg::SLOW_LIMIT_RST;
        endfunction

        function void set_reg(cir_pkg::cfg_reg_t idx, logic [cir_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                cir_pkg::CFG_CORR_FRAC:  corr_frac  = data[cir_pkg::FRAC_CFG_W-1:0];
                cir_pkg::CFG_PEN_SLOP:   pen_slop   = data[cir_pkg::LIMIT_W-1:0];
                cir_pkg::CFG_BOUNCE:     bounce     = data[cir_pkg::FRAC_CFG_W-1:0];
                cir_pkg::CFG_SLOW_LIMIT: slow_limit = data[cir_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function big_t clamp(big_t x);
            big_t hi;
            hi = (big_t'(1) <<< 31) - 1;
            if (x > hi)
            begin
                return hi;
            end
            if (x < -hi - 1)
            begin
                return -hi - 1;
            end
            return x;
        endfunction

        // Q16.16 product, floored.
        function big_t qmul(big_t a, big_t b);
            big_t p;
            p = a * b;
            return p >>> 16;
        endfunction

        function void remove_normal(ref big_t v[3], input big_t n[3]);
            big_t d;
            d = clamp(qmul(v[0], n[0]) + qmul(v[1], n[1]) + qmul(v[2], n[2]));
            for (int i = 0; i < 3; i++)
            begin
                v[i] = clamp(v[i] - qmul(n[i], d));
            end
        endfunction

        function cir_pkg::result_t resolve(cir_pkg::contact_t c);
            big_t             ma;
            big_t             mb;
            big_t             total;
            big_t             n[3];
            big_t             va[3];
            big_t             vb[3];
            big_t             sa[3];
            big_t             sb[3];
            big_t             ex;
            big_t             s;
            big_t             f;
            big_t             cc;
            big_t             rel;
            big_t             m;
            big_t             j;
            big_t             imp;
            cir_pkg::result_t r;
            ma = c.inv_mass_a;
            mb = c.inv_mass_b;
            total = ma + mb;
            n[0] = c.normal_x;  n[1] = c.normal_y;  n[2] = c.normal_z;
            va[0] = c.vel_a_x;  va[1] = c.vel_a_y;  va[2] = c.vel_a_z;
            vb[0] = c.vel_b_x;  vb[1] = c.vel_b_y;  vb[2] = c.vel_b_z;
            for (int i = 0; i < 3; i++)
            begin
                sa[i] = 0;
                sb[i] = 0;
            end
            if (total > 0)
            begin
                ex = big_t'(c.depth) - big_t'(pen_slop);
                if (ex > 0)
                begin
                    s = clamp(qmul(ex, big_t'(corr_frac)));
                    f = clamp((s <<< 16) / total);
                    for (int i = 0; i < 3; i++)
                    begin
                        cc = clamp(qmul(n[i], f));
                        sa[i] = clamp(-qmul(cc, ma));
                        sb[i] = clamp(qmul(cc, mb));
                    end
                end
                rel = 0;
                for (int i = 0; i < 3; i++)
                begin
                    rel = rel + qmul(vb[i] - va[i], n[i]);
                end
                rel = clamp(rel);
                if (rel <= 0)
                begin
                    if (-rel < big_t'(slow_limit))
                    begin
                        remove_normal(va, n);
                        remove_normal(vb, n);
                    end
                    else
                    begin
                        m = clamp(qmul(big_t'(65536) + big_t'(bounce), -rel));
                        j = clamp((m <<< 16) / total);
                        for (int i = 0; i < 3; i++)
                        begin
                            imp = clamp(qmul(n[i], j));
                            va[i] = clamp(va[i] - qmul(imp, ma));
                            vb[i] = clamp(vb[i] + qmul(imp, mb));
                        end
                    end
                end
            end
            r.shift_a_x = cir_pkg::val_t'(sa[0]);  r.shift_a_y = cir_pkg::val_t'(sa[1]);
            r.shift_a_z = cir_pkg::val_t'(sa[2]);
            r.shift_b_x = cir_pkg::val_t'(sb[0]);  r.shift_b_y = cir_pkg::val_t'(sb[1]);
            r.shift_b_z = cir_pkg::val_t'(sb[2]);
            r.new_vel_a_x = cir_pkg::val_t'(va[0]);  r.new_vel_a_y = cir_pkg::val_t'(va[1]);
            r.new_vel_a_z = cir_pkg::val_t'(va[2]);
            r.new_vel_b_x = cir_pkg::val_t'(vb[0]);  r.new_vel_b_y = cir_pkg::val_t'(vb[1]);
            r.new_vel_b_z = cir_pkg::val_t'(vb[2]);
            return r;
        endfunction

        function void note_contact(cir_pkg::contact_t c);
            pending.push_back(resolve(c));
        endfunction

        function void check_result(cir_pkg::result_t got);
            cir_pkg::result_t  want;
            logic [11:0][31:0] g;
            logic [11:0][31:0] w;
            string             names[12];
            names = '{"shift_a_x", "shift_a_y", "shift_a_z", "shift_b_x",
                      "shift_b_y", "shift_b_z", "new_vel_a_x", "new_vel_a_y",
                      "new_vel_a_z", "new_vel_b_x", "new_vel_b_y", "new_vel_b_z"};
            if (pending.size() == 0)
            begin
                faults.push_back("result item with no contact outstanding");
                return;
            end
            want = pending.pop_front();
            g = got;
            w = want;
            // packed order puts shift_a_x in the top word
            for (int i = 0; i < 12; i++)
            begin
                if (g[11-i] !== w[11-i])
                begin
                    faults.push_back($sformatf("%s: got %0d, want %0d", names[i],
                        $signed(g[11-i]), $signed(w[11-i])));
                end
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           contact_valid;
    logic                           contact_ready;
    cir_pkg::contact_t              contact;
    logic                           result_valid;
    logic                           result_ready;
    cir_pkg::result_t               result;
    logic                           cfg_we;
    cir_pkg::cfg_reg_t              cfg_index;
    logic [cir_pkg::CFG_DATA_W-1:0] cfg_data;

    contact_scoreboard sb;
    int                error_count;
    int                stall_left;

    contact_impulse_resolver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .contact_valid (contact_valid),
        .contact_ready (contact_ready),
        .contact       (contact),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Note accepted contacts and check accepted results at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (contact_valid && contact_ready)
            begin
                sb.note_contact(contact);
            end
            if (result_valid && result_ready)
            begin
                sb.check_result(result);
            end
            while (sb.faults.size() > 0)
            begin
                report(sb.faults.pop_front());
            end
        end
    end

    // Receiver: long ready stretches, short stalls, a few long ones.
    always @(posedge clk)
    begin
        int pick;
        if (stall_left > 0)
        begin
            stall_left--;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                result_ready <= 1'b1;
                stall_left = $urandom_range(0, 30);
            end
            else if (pick < 95)
            begin
                result_ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
            begin
                result_ready <= 1'b0;
                stall_left = $urandom_range(10, 60);
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            return 0;
        end
        if (pick < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    // Write one register, then hold the port idle before returning.
    task automatic write_reg(cir_pkg::cfg_reg_t idx, logic [cir_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Hold the item until accepted, then optionally drop valid for a gap.
    task automatic send(cir_pkg::contact_t c);
        int gap;
        contact       <= c;
        contact_valid <= 1'b1;
        @(posedge clk);
        while (!contact_ready)
        begin
            @(posedge clk);
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            contact_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic cir_pkg::val_t rand_val(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            default: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
    endfunction

    function automatic cir_pkg::contact_t rand_contact();
        cir_pkg::contact_t c;
        int                axis;
        int                mode;
        mode = $urandom_range(0, 9);
        c.inv_mass_a = (mode == 0) ? cir_pkg::mass_t'($urandom)
                                   : cir_pkg::mass_t'($urandom_range(0, 1 << 18));
        c.inv_mass_b = (mode == 1) ? cir_pkg::mass_t'($urandom)
                                   : cir_pkg::mass_t'($urandom_range(0, 1 << 18));
        if ($urandom_range(0, 19) == 0)
        begin
            c.inv_mass_a = '0;
            c.inv_mass_b = '0;
        end
        if (mode == 2)
        begin
            c.normal_x = rand_val(0);
            c.normal_y = rand_val(0);
            c.normal_z = rand_val(0);
        end
        else
        begin
            // mostly a near-unit normal along one axis
            c.normal_x = rand_val(2) >>> 4;
            c.normal_y = rand_val(2) >>> 4;
            c.normal_z = rand_val(2) >>> 4;
            axis = $urandom_range(0, 2);
            case (axis)
                0: c.normal_x = $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
                1: c.normal_y = $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
                default: c.normal_z = $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
            endcase
        end
        c.depth   = (mode == 3) ? rand_val(0) : rand_val(2);
        c.vel_a_x = rand_val(mode == 4 ? 0 : 1);
        c.vel_a_y = rand_val(mode == 4 ? 0 : 1);
        c.vel_a_z = rand_val(mode == 4 ? 0 : 1);
        c.vel_b_x = rand_val(mode == 5 ? 0 : 1);
        c.vel_b_y = rand_val(mode == 5 ? 0 : 1);
        c.vel_b_z = rand_val(mode == 5 ? 0 : 1);
        // slow approach: shrink velocities so the normal speed stays small
        if (mode == 6)
        begin
            c.vel_a_x = c.vel_a_x >>> 8;  c.vel_a_y = c.vel_a_y >>> 8;
            c.vel_a_z = c.vel_a_z >>> 8;  c.vel_b_x = c.vel_b_x >>> 8;
            c.vel_b_y = c.vel_b_y >>> 8;  c.vel_b_z = c.vel_b_z >>> 8;
        end
        return c;
    endfunction

    function automatic cir_pkg::contact_t make_contact(cir_pkg::mass_t ma, cir_pkg::mass_t mb,
        cir_pkg::val_t nx, cir_pkg::val_t ny, cir_pkg::val_t nz, cir_pkg::val_t dp,
        cir_pkg::val_t va, cir_pkg::val_t vb);
        cir_pkg::contact_t c;
        c.inv_mass_a = ma;  c.inv_mass_b = mb;
        c.normal_x = nx;    c.normal_y = ny;    c.normal_z = nz;
        c.depth = dp;
        c.vel_a_x = va;     c.vel_a_y = -va;    c.vel_a_z = va >>> 1;
        c.vel_b_x = vb;     c.vel_b_y = vb >>> 2; c.vel_b_z = -vb;
        return c;
    endfunction

    task automatic directed();
        cir_pkg::mass_t mmax;
        cir_pkg::val_t  one;
        cir_pkg::val_t  vmin;
        cir_pkg::val_t  vmax;
        mmax = '1;
        one  = 32'sd65536;
        vmin = {1'b1, 31'd0};
        vmax = cir_pkg::VAL_MAX;
        // immovable pair
        send(make_contact('0, '0, one, 0, 0, 32'sd200000, 32'sd70000, -32'sd70000));
        // one body immovable, deep penetration, fast approach
        send(make_contact('0, 31'd65536, one, 0, 0, 32'sd300000, 32'sd200000, 0));
        send(make_contact(31'd65536, '0, 0, one, 0, 32'sd300000, 0, -32'sd200000));
        // separating
        send(make_contact(31'd65536, 31'd65536, one, 0, 0, 0, -32'sd100000, 32'sd100000));
        // slow approach
        send(make_contact(31'd65536, 31'd32768, 0, 0, one, 32'sd1000, 32'sd1000, 0));
        // impulse along negative normal
        send(make_contact(31'd131072, 31'd65536, -one, 0, 0, 32'sd65536,
            -32'sd500000, 32'sd500000));
        // depth exactly at slop, just above, and negative
        send(make_contact(31'd65536, 31'd65536, one, 0, 0, 32'sd655, 32'sd1, 0));
        send(make_contact(31'd65536, 31'd65536, one, 0, 0, 32'sd656, 32'sd1, 0));
        send(make_contact(31'd65536, 31'd65536, one, 0, 0, vmin, 0, 0));
        // field extremes and saturation
        send(make_contact(mmax, mmax, vmax, vmax, vmax, vmax, vmax, vmin));
        send(make_contact(mmax, 31'd1, vmin, vmin, vmin, vmax, vmin, vmax));
        send(make_contact(31'd1, mmax, vmax, vmin, 0, vmax, vmax, vmax));
        send(make_contact(31'd1, 31'd1, one, one, one, vmax, vmax, vmin));
        send(make_contact(mmax, mmax, 0, 0, 0, vmin, vmin, vmin));
        send(make_contact(31'd1, '0, -1, -1, -1, -1, -1, -1));
    endtask

    task automatic random_phase(int count);
        int pause_at;
        pause_at = $urandom_range(0, count - 1);
        for (int k = 0; k < count; k++)
        begin
            if (k == pause_at)
            begin
                contact_valid <= 1'b0;
                wait_drained();
            end
            send(rand_contact());
        end
        contact_valid <= 1'b0;
        wait_drained();
    endtask

    initial
    begin
        sb = new();
        sb.load_defaults();
        error_count   = 0;
        stall_left    = 0;
        rst_n         = 1'b0;
        contact_valid = 1'b0;
        contact       = '0;
        result_ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = cir_pkg::CFG_CORR_FRAC;
        cfg_data      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed();
        random_phase(300);

        // all zero
        write_reg(cir_pkg::CFG_CORR_FRAC, '0);
        write_reg(cir_pkg::CFG_PEN_SLOP, '0);
        write_reg(cir_pkg::CFG_BOUNCE, '0);
        write_reg(cir_pkg::CFG_SLOW_LIMIT, '0);
        directed();
        random_phase(300);

        // stated maxima
        write_reg(cir_pkg::CFG_CORR_FRAC, 31'd65536);
        write_reg(cir_pkg::CFG_PEN_SLOP, 31'h7FFF_FFFF);
        write_reg(cir_pkg::CFG_BOUNCE, 31'd65536);
        write_reg(cir_pkg::CFG_SLOW_LIMIT, 31'h7FFF_FFFF);
        random_phase(250);

        // full bit width, above the stated range
        write_reg(cir_pkg::CFG_CORR_FRAC, '1);
        write_reg(cir_pkg::CFG_PEN_SLOP, 31'd0);
        write_reg(cir_pkg::CFG_BOUNCE, '1);
        write_reg(cir_pkg::CFG_SLOW_LIMIT, 31'd100);
        random_phase(250);

        for (int p = 0; p < 3; p++)
        begin
            write_reg(cir_pkg::CFG_CORR_FRAC, $urandom);
            write_reg(cir_pkg::CFG_PEN_SLOP, $urandom_range(0, 1 << 17));
            write_reg(cir_pkg::CFG_BOUNCE, $urandom);
            write_reg(cir_pkg::CFG_SLOW_LIMIT, $urandom_range(0, 1 << 19));
            random_phase(200);
        end

        repeat (100) @(posedge clk);
        if (error_count == 0 && sb.pending.size() == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("testbench: done, errors");
        $finish;
    end
endmodule
